// ----- rtl/core/fk_pkg.sv -----
// Shared constants, register codes and trig tables for the arm kinematics unit.
package fk_pkg;

  // Port widths
  localparam int ANG_W     = 16;
  localparam int SUM_W     = 17;
  localparam int EXT_W     = 15;
  localparam int DIST_W    = 16;
  localparam int LEN_W     = 16;
  localparam int POS_W     = 18;
  localparam int STAMP_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int ZW        = 34;

  // Defaults for the top-level parameters
  localparam int TRIG_STAGES_DEF    = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd2;

  localparam logic signed [ANG_W-1:0] TILT_RST   = 16'sd4200;
  localparam logic signed [ANG_W-1:0] OFFSET_RST = 16'sd5000;
  localparam logic [LEN_W-1:0]        BASE_RST   = 16'd3470;

  // Angle conversion: 2^32 = 36000 * TURN_Q + TURN_R
  localparam logic [17:0] FULL_TURN = 18'd36000;
  localparam logic [31:0] TURN_Q    = 32'd119304;
  localparam logic [29:0] TURN_R    = 30'd23296;
  localparam logic [29:0] HALF_UNIT = 30'd18000;
  // floor(n / 36000) = (n * RECIP_M) >> RECIP_S for n < 2^30
  localparam logic [60:0] RECIP_M   = 61'd1954687339;
  localparam int          RECIP_S   = 46;

  localparam longint GAIN_Q30 = 64'd652032874;
  localparam logic signed [POS_W-1:0] POS_MAX = 18'sd131071;
  localparam logic signed [POS_W-1:0] POS_MIN = -18'sd131072;

  // atan(2^-i) in units of 2^-32 turn, zero past the table
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Beat carried beside the trig pipeline
  typedef struct packed {
    logic signed [DIST_W-1:0] neg_ext;
    logic [LEN_W-1:0]         base;
    logic [STAMP_W-1:0]       stamp;
  } side_t;

endpackage

// ----- rtl/core/fk_angle_prep.sv -----
// Three-stage conversion of a hundredths-of-degree angle to a CORDIC start angle.
module fk_angle_prep (
  input  logic                             clk,
  input  logic signed [fk_pkg::SUM_W-1:0]  ang_i,
  output logic signed [fk_pkg::ZW-1:0]     z_o,
  output logic                             flip_o
);
  import fk_pkg::*;

  logic [15:0] hm_r, hm_nxt;
  logic [29:0] n_r, n_nxt;
  logic [14:0] q_r, q_nxt;
  logic [31:0] base_r, base_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic flip_r, flip_nxt;

  // Reduce modulo a full turn and form the remainder numerator
  always_comb begin
    logic signed [17:0] tmp;
    logic [17:0] t;
    tmp = {ang_i[SUM_W-1], ang_i} + 18'sd72000;
    t = tmp;
    for (int k = 0; k < 3; k++) begin
      if (t >= FULL_TURN) t = t - FULL_TURN;
    end
    hm_nxt = t[15:0];
    n_nxt  = 30'({14'd0, hm_nxt} * TURN_R) + HALF_UNIT;
  end

  // Divide the remainder by a full turn, scale the whole part
  always_comb begin
    logic [60:0] qp;
    qp       = 61'(n_r) * RECIP_M;
    q_nxt    = 15'(qp >> RECIP_S);
    base_nxt = 32'({16'd0, hm_r} * TURN_Q);
  end

  // Fold angles beyond a right angle into the CORDIC range
  always_comb begin
    logic [31:0] b;
    b = base_r + {17'd0, q_r};
    flip_nxt = (b >= 32'h40000000) && (b < 32'hC0000000);
    if (flip_nxt) b = b + 32'h80000000;
    z_nxt = {{(ZW-32){b[31]}}, b};
  end

  always_ff @(posedge clk) begin
    hm_r   <= hm_nxt;
    n_r    <= n_nxt;
    q_r    <= q_nxt;
    base_r <= base_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign z_o    = z_r;
  assign flip_o = flip_r;

endmodule

// ----- rtl/core/fk_cordic.sv -----
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module fk_cordic #(
  parameter int TRIG_STAGES    = fk_pkg::TRIG_STAGES_DEF,
  parameter int TRIG_FRAC_BITS = fk_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic signed [fk_pkg::ZW-1:0]    z_i,
  input  logic                            flip_i,
  output logic signed [TRIG_FRAC_BITS+2:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+2:0] cos_o
);
  import fk_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 3;
  localparam logic signed [TW-1:0] X0 = TW'(GAIN_Q30 >>> (30 - TRIG_FRAC_BITS));

  logic signed [TW-1:0] x_r [TRIG_STAGES];
  logic signed [TW-1:0] y_r [TRIG_STAGES];
  logic signed [ZW-1:0] z_r [TRIG_STAGES];
  logic                 f_r [TRIG_STAGES];

  // One micro-rotation per stage
  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    logic signed [TW-1:0] xi, yi, x_nxt, y_nxt;
    logic signed [ZW-1:0] zi, z_nxt, da;
    logic                 fi;
    if (i == 0) begin : g_first
      assign xi = X0;
      assign yi = '0;
      assign zi = z_i;
      assign fi = flip_i;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = f_r[i-1];
    end
    assign da = {{(ZW-32){1'b0}}, atan_turn(i)};
    always_comb begin
      if (!zi[ZW-1]) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - da;
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + da;
      end
    end
    always_ff @(posedge clk) begin
      x_r[i] <= x_nxt;
      y_r[i] <= y_nxt;
      z_r[i] <= z_nxt;
      f_r[i] <= fi;
    end
  end

  // Undo the half-turn fold
  assign sin_o = f_r[TRIG_STAGES-1] ? -y_r[TRIG_STAGES-1] : y_r[TRIG_STAGES-1];
  assign cos_o = f_r[TRIG_STAGES-1] ? -x_r[TRIG_STAGES-1] : x_r[TRIG_STAGES-1];

endmodule

// ----- rtl/core/fk_combine.sv -----
// Four-stage product, sum, rounding and saturation of the tool position.
module fk_combine #(
  parameter int TRIG_FRAC_BITS = fk_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  fk_pkg::side_t                     side_i,
  input  logic signed [TRIG_FRAC_BITS+2:0]  st_i,
  input  logic signed [TRIG_FRAC_BITS+2:0]  ct_i,
  input  logic signed [TRIG_FRAC_BITS+2:0]  sp_i,
  input  logic signed [TRIG_FRAC_BITS+2:0]  cp_i,
  input  logic signed [TRIG_FRAC_BITS+2:0]  sb_i,
  input  logic signed [TRIG_FRAC_BITS+2:0]  cb_i,
  output logic                              vld_o,
  output logic signed [fk_pkg::POS_W-1:0]   x_o,
  output logic signed [fk_pkg::POS_W-1:0]   y_o,
  output logic signed [fk_pkg::POS_W-1:0]   z_o,
  output logic [fk_pkg::STAMP_W-1:0]        stamp_o
);
  import fk_pkg::*;

  localparam int F  = TRIG_FRAC_BITS;
  localparam int TW = F + 3;
  localparam int DW = TW + DIST_W;
  localparam int LW = TW + LEN_W + 1;
  localparam int SW = TW + 19;
  localparam int RW = SW - F;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
  localparam logic signed [RW-1:0] RMAX = RW'(POS_MAX);
  localparam logic signed [RW-1:0] RMIN = RW'(POS_MIN);

  function automatic logic signed [TW-1:0] pm(input logic signed [TW-1:0] a,
                                               input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b;
    return TW'(p >>> F);
  endfunction

  function automatic logic signed [POS_W-1:0] fin(input logic signed [SW-1:0] v);
    logic signed [RW-1:0] r;
    logic signed [SW-1:0] s;
    s = (v + HALF) >>> F;
    r = RW'(s);
    if (r > RMAX) r = RMAX;
    if (r < RMIN) r = RMIN;
    return POS_W'(r);
  endfunction

  logic [3:0] vld_r;
  side_t s1_r, s2_r, s3_r;

  // Stage 1: pairwise trig products and base-length terms
  logic signed [TW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, sb1_r;
  logic signed [LW-1:0] tl1_r, tc1_r;
  always_ff @(posedge clk) begin
    p1_r  <= pm(st_i, cb_i);
    p2_r  <= pm(ct_i, cp_i);
    p3_r  <= pm(sp_i, sb_i);
    p4_r  <= pm(ct_i, cb_i);
    p5_r  <= pm(cp_i, st_i);
    sb1_r <= sb_i;
    tl1_r <= st_i * $signed({1'b0, side_i.base});
    tc1_r <= ct_i * $signed({1'b0, side_i.base});
    s1_r  <= side_i;
  end

  // Stage 2: triple products and first distance terms
  logic signed [TW-1:0] q2_r, q5_r;
  logic signed [DW-1:0] a1_r, a3_r, a4_r;
  logic signed [LW-1:0] tl2_r, tc2_r;
  always_ff @(posedge clk) begin
    q2_r  <= pm(p2_r, sb1_r);
    q5_r  <= pm(p5_r, sb1_r);
    a1_r  <= p1_r * s1_r.neg_ext;
    a3_r  <= p3_r * s1_r.neg_ext;
    a4_r  <= p4_r * s1_r.neg_ext;
    tl2_r <= tl1_r;
    tc2_r <= tc1_r;
    s2_r  <= s1_r;
  end

  // Stage 3: remaining distance terms and the sums
  logic signed [DW-1:0] m2, m5;
  logic signed [SW-1:0] xs_r, ys_r, zs_r;
  assign m2 = q2_r * s2_r.neg_ext;
  assign m5 = q5_r * s2_r.neg_ext;
  always_ff @(posedge clk) begin
    xs_r <= SW'(a1_r) + SW'(m2) + SW'(tl2_r);
    ys_r <= SW'(a3_r);
    zs_r <= SW'(a4_r) - SW'(m5) + SW'(tc2_r);
    s3_r <= s2_r;
  end

  // Stage 4: round to nearest and saturate into the output registers
  always_ff @(posedge clk) begin
    x_o     <= fin(xs_r);
    y_o     <= fin(ys_r);
    z_o     <= fin(zs_r);
    stamp_o <= s3_r.stamp;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end
  assign vld_o = vld_r[3];

endmodule

// ----- rtl/core/arm_forward_kinematics_unit.sv -----
// Top level of the arm forward kinematics unit: config, side pipe, trig and combine.
//
//  channel  ports                                   handshake
//  input    in_* (angles, extension, stamp)         start high while busy low
//  result   out_* (x, y, z position, stamp)          out_valid for one cycle
//  config   cfg_we, cfg_index, cfg_data             cfg_we, no wait
//
// One beat may enter every cycle while busy is low. It passes TRIG_STAGES + 7
// register stages (3 angle conversion stages, one CORDIC stage per
// micro-rotation, 4 product and rounding stages), the first loaded at the
// accepting edge; out_valid rises as the last of them is loaded.
// Synchronous reset clears valid bits and restores register defaults; busy is
// high during reset and in the first cycle after it. The receiver cannot
// stall, so the pipeline never holds.
module arm_forward_kinematics_unit #(
  parameter int TRIG_STAGES    = fk_pkg::TRIG_STAGES_DEF,
  parameter int TRIG_FRAC_BITS = fk_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fk_pkg::ANG_W-1:0]    in_first_joint_angle,
  input  logic signed [fk_pkg::ANG_W-1:0]    in_second_joint_angle,
  input  logic signed [fk_pkg::EXT_W-1:0]    in_extension,
  input  logic [fk_pkg::STAMP_W-1:0]         in_stamp_in,
  output logic                               out_valid,
  output logic signed [fk_pkg::POS_W-1:0]    out_x_position,
  output logic signed [fk_pkg::POS_W-1:0]    out_y_position,
  output logic signed [fk_pkg::POS_W-1:0]    out_z_position,
  output logic [fk_pkg::STAMP_W-1:0]         out_stamp_out,
  input  logic                               cfg_we,
  input  logic [fk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fk_pkg::CFG_W-1:0]           cfg_data
);
  import fk_pkg::*;

  localparam int TW  = TRIG_FRAC_BITS + 3;
  localparam int SD  = TRIG_STAGES + 3;
  localparam int LAT = TRIG_STAGES + 7;

  logic signed [ANG_W-1:0] tilt_r, offset_r;
  logic [LEN_W-1:0]        base_r;
  logic                    busy_r;
  logic                    accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_r   <= TILT_RST;
      offset_r <= OFFSET_RST;
      base_r   <= BASE_RST;
      busy_r   <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_TILT:   tilt_r   <= cfg_data;
          REG_OFFSET: offset_r <= cfg_data;
          REG_BASE:   base_r   <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  // Angle conversion for tilt, first joint, and second joint plus offset
  logic signed [SUM_W-1:0] a_tilt, a_phi, a_beta;
  logic signed [ZW-1:0]    z_t, z_p, z_b;
  logic                    f_t, f_p, f_b;
  assign a_tilt = {tilt_r[ANG_W-1], tilt_r};
  assign a_phi  = {in_first_joint_angle[ANG_W-1], in_first_joint_angle};
  assign a_beta = {in_second_joint_angle[ANG_W-1], in_second_joint_angle}
                + {offset_r[ANG_W-1], offset_r};

  fk_angle_prep u_prep_t (.clk(clk), .ang_i(a_tilt), .z_o(z_t), .flip_o(f_t));
  fk_angle_prep u_prep_p (.clk(clk), .ang_i(a_phi),  .z_o(z_p), .flip_o(f_p));
  fk_angle_prep u_prep_b (.clk(clk), .ang_i(a_beta), .z_o(z_b), .flip_o(f_b));

  logic signed [TW-1:0] st, ct, sp, cp, sb, cb;

  fk_cordic #(.TRIG_STAGES(TRIG_STAGES), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_t (
    .clk(clk), .z_i(z_t), .flip_i(f_t), .sin_o(st), .cos_o(ct));
  fk_cordic #(.TRIG_STAGES(TRIG_STAGES), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_p (
    .clk(clk), .z_i(z_p), .flip_i(f_p), .sin_o(sp), .cos_o(cp));
  fk_cordic #(.TRIG_STAGES(TRIG_STAGES), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_b (
    .clk(clk), .z_i(z_b), .flip_i(f_b), .sin_o(sb), .cos_o(cb));

  // Side pipe: negated extension, base length and stamp beside the trig units
  side_t side_in;
  side_t side_r [SD];
  logic [SD-1:0] vld_r;
  always_comb begin
    side_in.neg_ext = -{in_extension[EXT_W-1], in_extension};
    side_in.base    = base_r;
    side_in.stamp   = in_stamp_in;
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int k = 1; k < SD; k++) side_r[k] <= side_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SD-2:0], accept};
    end
  end

  fk_combine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_comb (
    .clk(clk), .rst_n(rst_n), .vld_i(vld_r[SD-1]), .side_i(side_r[SD-1]),
    .st_i(st), .ct_i(ct), .sp_i(sp), .cp_i(cp), .sb_i(sb), .cb_i(cb),
    .vld_o(out_valid), .x_o(out_x_position), .y_o(out_y_position),
    .z_o(out_z_position), .stamp_o(out_stamp_out));

  // Every result traces back to a beat accepted at the head of the full pipeline
  a_out_src: assert property (@(posedge clk) out_valid |-> $past(accept, LAT))
    else $error("result without a matching accepted beat");
  // Reset leaves no result pending
  a_rst_clr: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("result strobe right after reset");
  // Once out of reset the unit always takes a beat
  a_no_busy: assert property (@(posedge clk) rst_n && $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

// ----- sim/fk_checker.sv -----
// Watches the arm kinematics unit, predicts each position beat and compares it.
module fk_checker #(
  parameter int TRIG_STAGES    = fk_pkg::TRIG_STAGES_DEF,
  parameter int TRIG_FRAC_BITS = fk_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [fk_pkg::ANG_W-1:0] in_first_joint_angle,
  input  logic signed [fk_pkg::ANG_W-1:0] in_second_joint_angle,
  input  logic signed [fk_pkg::EXT_W-1:0] in_extension,
  input  logic [fk_pkg::STAMP_W-1:0]      in_stamp_in,
  input  logic                            out_valid,
  input  logic signed [fk_pkg::POS_W-1:0] out_x_position,
  input  logic signed [fk_pkg::POS_W-1:0] out_y_position,
  input  logic signed [fk_pkg::POS_W-1:0] out_z_position,
  input  logic [fk_pkg::STAMP_W-1:0]      out_stamp_out,
  input  logic                            cfg_we,
  input  logic [fk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fk_pkg::CFG_W-1:0]        cfg_data,
  output int                              fail_count,
  output int                              positions_due,
  output int                              items_seen,
  output int                              positions_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import fk_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [STAMP_W-1:0]      stamp;
  } position_t;

  // micro-rotation steps in 2^-32 turn
  localparam longint ROT_STEP [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
    64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

  position_t  position_q[$];
  logic signed [ANG_W-1:0] tilt_q;
  logic signed [ANG_W-1:0] offset_q;
  logic [LEN_W-1:0]        base_q;

  // sine and cosine in Q(F) of an angle in hundredths of a degree
  function automatic void trig(input longint hund, output longint s, output longint c);
    longint hm, x, y, z, dx, dy, da;
    longint unsigned turn;
    logic [31:0] b;
    logic flip;
    hm = hund % 36000;
    if (hm < 0) hm += 36000;
    turn = ((longint'(hm) << 32) + 18000) / 36000;
    b = turn[31:0];
    flip = 1'b0;
    // fold the far half circle onto the near one
    if (b >= 32'h40000000 && b < 32'hC0000000) begin
      b = b + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'(signed'(b));
    x = GAIN_Q30 >>> (30 - TRIG_FRAC_BITS);
    y = 0;
    for (int i = 0; i < TRIG_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = (i < 24) ? ROT_STEP[i] : 0;
      if (z >= 0) begin
        x -= dx; y += dy; z -= da;
      end else begin
        x += dx; y -= dy; z += da;
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint fmul(input longint a, input longint b);
    return (a * b) >>> TRIG_FRAC_BITS;
  endfunction

  // round to nearest, then clamp to the port range
  function automatic logic signed [POS_W-1:0] round_sat(input longint v);
    longint r;
    r = (v + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (r > POS_MAX) r = POS_MAX;
    if (r < POS_MIN) r = POS_MIN;
    return r[POS_W-1:0];
  endfunction

  function automatic position_t tool_position(input longint phi, input longint psi,
                                              input longint ext, input logic [31:0] stamp);
    longint st, ct, sp, cp, sb, cb, d, len, x, y, z;
    position_t p;
    d = -ext;
    len = base_q;
    trig(tilt_q, st, ct);
    trig(phi, sp, cp);
    trig(psi + offset_q, sb, cb);
    x = fmul(st, cb) * d + fmul(fmul(ct, cp), sb) * d + st * len;
    y = fmul(sp, sb) * d;
    z = fmul(ct, cb) * d - fmul(fmul(cp, st), sb) * d + ct * len;
    p.x = round_sat(x);
    p.y = round_sat(y);
    p.z = round_sat(z);
    p.stamp = stamp;
    return p;
  endfunction

  always @(posedge clk) begin
    position_t want;
    if (!rst_n) begin
      tilt_q <= TILT_RST;
      offset_q <= OFFSET_RST;
      base_q <= BASE_RST;
      position_q.delete();
      fail_count <= 0;
      positions_due <= 0;
      items_seen <= 0;
      positions_seen <= 0;
    end else begin
      // track register writes; index 3 is dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_TILT:   tilt_q <= signed'(cfg_data);
          REG_OFFSET: offset_q <= signed'(cfg_data);
          REG_BASE:   base_q <= cfg_data;
          default: ;
        endcase
      end
      // predict on each accepted beat
      if (start && !busy) begin
        position_q.insert(position_q.size(),
                          tool_position(in_first_joint_angle, in_second_joint_angle,
                                        in_extension, in_stamp_in));
        items_seen <= items_seen + 1;
      end
      // compare each result beat with the oldest prediction
      if (out_valid) begin
        positions_seen <= positions_seen + 1;
        if (position_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = position_q.pop_front();
          if (out_x_position !== want.x || out_y_position !== want.y ||
              out_z_position !== want.z || out_stamp_out !== want.stamp)
            fail_count <= fail_count + 1;
          if (out_x_position !== want.x)
            $error("x_position expected %0d got %0d", want.x, out_x_position);
          if (out_y_position !== want.y)
            $error("y_position expected %0d got %0d", want.y, out_y_position);
          if (out_z_position !== want.z)
            $error("z_position expected %0d got %0d", want.z, out_z_position);
          if (out_stamp_out !== want.stamp)
            $error("stamp_out expected %0h got %0h", want.stamp, out_stamp_out);
        end
      end
      positions_due <= position_q.size();
    end
  end

endmodule

// ----- sim/tb_arm_forward_kinematics_unit.sv -----
// Stimulus, register phases and verdict for the arm forward kinematics unit.
module tb_arm_forward_kinematics_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fk_pkg::*;

  localparam int LATENCY = TRIG_STAGES_DEF + 7;
  localparam int N_PHASE = 6;
  localparam int PHASE_ITEMS = 134;

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  logic signed [ANG_W-1:0] in_first_joint_angle, in_second_joint_angle;
  logic signed [EXT_W-1:0] in_extension;
  logic [STAMP_W-1:0]      in_stamp_in, out_stamp_out;
  logic signed [POS_W-1:0] out_x_position, out_y_position, out_z_position;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  int fail_count, positions_due, items_seen, positions_seen;

  arm_forward_kinematics_unit uut (.*);
  fk_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // hold start high until the beat is taken
  task automatic send_beat(input logic signed [15:0] phi, input logic signed [15:0] psi,
                           input logic signed [14:0] ext, input logic [31:0] stamp);
    in_first_joint_angle <= phi;
    in_second_joint_angle <= psi;
    in_extension <= ext;
    in_stamp_in <= stamp;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // idle the sender for a random run of cycles, each idle with the given odds
  task automatic maybe_idle(input int rate);
    while ($urandom_range(99) < rate) begin
      start <= 1'b0;
      in_stamp_in <= $urandom;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_angle();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(36000) - 18000);
    if (r < 80) return 16'($urandom);
    case ($urandom_range(4))
      0: return 16'sd0;
      1: return 16'sd9000;
      2: return -16'sd9000;
      3: return 16'sd18000;
      default: return -16'sd18000;
    endcase
  endfunction

  function automatic logic signed [14:0] pick_ext();
    if ($urandom_range(3) == 0) return 15'($urandom);
    return 15'($urandom_range(20000) - 10000);
  endfunction

  // write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // drain the pipe
  task automatic drain();
    start <= 1'b0;
    while (positions_due != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  logic signed [15:0] tilt_set [N_PHASE] = '{-18000, 18000, 0, 9000, -32768, 32767};
  logic signed [15:0] offs_set [N_PHASE] = '{18000, -18000, 0, -9000, 32767, -32768};
  logic [15:0]        base_set [N_PHASE] = '{0, 65535, 3470, 1, 40000, 12345};

  initial begin
    int rate;
    start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_first_joint_angle = '0; in_second_joint_angle = '0;
    in_extension = '0; in_stamp_in = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: angle extremes, quadrant edges, extension extremes, stamp extremes
    send_beat(0, 0, 0, 32'h0);
    send_beat(18000, -18000, 10000, 32'hFFFF_FFFF);
    send_beat(-18000, 18000, -10000, 32'h1);
    send_beat(9000, -9000, 16383, 32'h8000_0000);
    send_beat(-9000, 9000, -16384, 32'h7FFF_FFFF);
    send_beat(32767, -32768, 1, 32'hA5A5_A5A5);
    send_beat(-32768, 32767, -1, 32'h5A5A_5A5A);
    send_beat(4500, 13500, 5000, 32'h1234_5678);
    send_beat(27000, -27000, -5000, 32'h0F0F_F0F0);
    send_beat(-13000, -5000, 10000, 32'hDEAD_0001);
    send_beat(1, -1, 10000, 32'hFFFF_0000);
    drain();
    // index 3 is not a register and must be dropped
    write_reg(2'd3, 16'hFFFF);
    cfg_we <= 1'b0;
    send_beat(4000, 4000, 3000, 32'hC0DE_0003);

    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain();
      write_reg(REG_TILT, tilt_set[ph]);
      write_reg(REG_OFFSET, offs_set[ph]);
      write_reg(REG_BASE, base_set[ph]);
      cfg_we <= 1'b0;
      rate = (ph < 2) ? 12 : (ph < 4) ? 53 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_beat(pick_angle(), pick_angle(), pick_ext(), $urandom);
        maybe_idle(rate);
      end
    end

    drain();
    $display("Covered %0d joint samples over %0d register settings; %0d positions checked.",
             items_seen, N_PHASE + 1, positions_seen);
    if (fail_count == 0 && positions_due == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
